>>> rtl/parallactic_angle_unit_macros.svh
// assertion macros shared by the rtl
`ifndef PARALLACTIC_ANGLE_UNIT_MACROS_SVH
`define PARALLACTIC_ANGLE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pa_pkg.sv
`timescale 1ns / 1ps
package pa_pkg;

    localparam int RW        = 34;   // rotation lane width, q2.30 plus headroom
    localparam int VW        = 52;   // vectoring lane width
    localparam int TABLE_LEN = 40;
    localparam logic signed [RW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef logic signed [RW-1:0] t_rw;
    typedef logic signed [VW-1:0] t_vw;

    typedef struct packed {
        t_rw x;
        t_rw y;
        t_rw z;
    } t_lane;

    typedef struct packed {
        t_lane      lat;
        t_lane      first;
        t_lane      second;
        logic [1:0] q_lat;
        logic [1:0] q_first;
        logic [1:0] q_second;
        logic       mode;
    } t_rot;

    typedef struct packed {
        t_vw         x;
        t_vw         y;
        logic [31:0] z;
        logic        zero;
    } t_vec;

    typedef struct packed {
        t_rw c;
        t_rw s;
    } t_cs;

    // arctangent of 2^-s in turn units
    function automatic logic [31:0] atan_turn(input int s);
        logic [31:0] r;
        case (s)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // one rotation micro-step towards z = 0
    function automatic t_lane rot_lane(input t_lane l, input int s);
        t_lane r;
        t_rw   a;
        a = t_rw'({2'b00, atan_turn(s)});
        if (!l.z[RW-1]) begin
            r.x = l.x - (l.y >>> s);
            r.y = l.y + (l.x >>> s);
            r.z = l.z - a;
        end else begin
            r.x = l.x + (l.y >>> s);
            r.y = l.y - (l.x >>> s);
            r.z = l.z + a;
        end
        return r;
    endfunction

    // quadrant restore of a rotated vector
    function automatic t_cs quad_fix(input t_lane l, input logic [1:0] q);
        t_cs r;
        case (q)
            2'd0:    begin r.c = l.x;  r.s = l.y;  end
            2'd1:    begin r.c = -l.y; r.s = l.x;  end
            2'd2:    begin r.c = -l.x; r.s = -l.y; end
            default: begin r.c = l.y;  r.s = -l.x; end
        endcase
        return r;
    endfunction

    // q2.30 product with floor
    function automatic t_rw qmul(input t_rw a, input t_rw b);
        logic signed [2*RW-1:0] p;
        p = a * b;
        return p[30 +: RW];
    endfunction

endpackage

>>> rtl/pa_rot_stage.sv
`timescale 1ns / 1ps
module pa_rot_stage import pa_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_rot i_data,
    output logic o_valid,
    output t_rot o_data
);

    logic r_valid;
    t_rot r_data;
    t_rot n_data;

    always_comb begin
        n_data        = i_data;
        n_data.lat    = rot_lane(i_data.lat, STEP);
        n_data.first  = rot_lane(i_data.first, STEP);
        n_data.second = rot_lane(i_data.second, STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/pa_vec_stage.sv
`timescale 1ns / 1ps
`include "parallactic_angle_unit_macros.svh"
module pa_vec_stage import pa_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_vec i_data,
    output logic o_valid,
    output t_vec o_data
);

    logic r_valid;
    t_vec r_data;
    t_vec n_data;
    logic [31:0] w_a;

    always_comb begin
        w_a    = atan_turn(STEP);
        n_data = i_data;
        // positive y turns clockwise
        if (!i_data.y[VW-1] && (i_data.y != '0)) begin
            n_data.x = i_data.x + (i_data.y >>> STEP);
            n_data.y = i_data.y - (i_data.x >>> STEP);
            n_data.z = i_data.z + w_a;
        end else begin
            n_data.x = i_data.x - (i_data.y >>> STEP);
            n_data.y = i_data.y + (i_data.x >>> STEP);
            n_data.z = i_data.z - w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // x is folded into the right half-plane and only grows from there
    `PA_ASSERT_IMP(a_x_nonneg, i_clk, i_rst_n, r_valid, !r_data.x[VW-1], "vectoring x negative")

endmodule

>>> rtl/parallactic_angle_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_mode, i_first_angle, i_second_angle
// result    out        o_valid / i_stall    o_position_angle
// config    in         i_cfg_we             i_cfg_data (observer latitude)
//
// one transfer accepted per cycle unless o_stall is high; a result passes two
// cordic chains of STEPS = min(CORDIC_STEPS, 40) registered stages each
// reset (i_rst_n low at a clock edge) empties every stage and clears latitude
// a stalled result freezes the whole pipeline; o_stall follows it directly
// latitude is sampled as an item enters
`include "parallactic_angle_unit_macros.svh"
module parallactic_angle_unit import pa_pkg::*; #(
    parameter int CORDIC_STEPS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic signed [31:0] i_first_angle,
    input  logic signed [31:0] i_second_angle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_position_angle
);

    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // latitude register
    logic [31:0] r_latitude;

    // global advance: everything moves unless a held result is stalled
    logic w_en;

    // rotation chain, index 0 is the input register
    t_rot rot_d [0:STEPS];
    logic rot_v [0:STEPS];

    // products
    logic r_m1_v, r_m2_v;
    t_rw  r_m1_p1, r_m1_p2, r_m1_p3, r_m1_cl;
    logic r_m1_mode;
    t_rw  r_m2_ty, r_m2_p2, r_m2_p4;

    // vectoring chain, index 0 is the scaled start vector
    t_vec vec_d [0:STEPS];
    logic vec_v [0:STEPS];

    t_rot n_s0;
    t_cs  w_lat, w_first, w_second;
    t_vec n_v0;
    logic signed [RW:0] w_tx;
    t_vw  w_xw, w_yw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latitude <= '0;
        end else if (i_cfg_we) begin
            r_latitude <= i_cfg_data;
        end
    end

    assign w_en    = !(vec_v[STEPS] && i_stall);
    assign o_stall = !w_en;

    // first quadrant residue of each angle, quadrant kept aside
    always_comb begin
        n_s0.lat      = '{x: INV_GAIN, y: '0, z: t_rw'({4'b0000, r_latitude[29:0]})};
        n_s0.first    = '{x: INV_GAIN, y: '0, z: t_rw'({4'b0000, i_first_angle[29:0]})};
        n_s0.second   = '{x: INV_GAIN, y: '0, z: t_rw'({4'b0000, i_second_angle[29:0]})};
        n_s0.q_lat    = r_latitude[31:30];
        n_s0.q_first  = i_first_angle[31:30];
        n_s0.q_second = i_second_angle[31:30];
        n_s0.mode     = i_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot_v[0] <= 1'b0;
        end else if (w_en) begin
            rot_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rot_d[0] <= n_s0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_rot
        pa_rot_stage #(.STEP(g)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (rot_v[g]),
            .i_data  (rot_d[g]),
            .o_valid (rot_v[g+1]),
            .o_data  (rot_d[g+1])
        );
    end

    // sines and cosines back in their quadrants
    always_comb begin
        w_lat    = quad_fix(rot_d[STEPS].lat, rot_d[STEPS].q_lat);
        w_first  = quad_fix(rot_d[STEPS].first, rot_d[STEPS].q_first);
        w_second = quad_fix(rot_d[STEPS].second, rot_d[STEPS].q_second);
    end

    // first products: cos(lat)sin(a1), sin(lat)cos(a2), sin(a2)cos(a1)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v <= rot_v[STEPS];
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_p1   <= qmul(w_lat.c, w_first.s);
            r_m1_p2   <= qmul(w_lat.s, w_second.c);
            r_m1_p3   <= qmul(w_second.s, w_first.c);
            r_m1_cl   <= w_lat.c;
            r_m1_mode <= rot_d[STEPS].mode;
            // second product and the sign of the y term
            r_m2_ty   <= r_m1_mode ? r_m1_p1 : -r_m1_p1;
            r_m2_p2   <= r_m1_p2;
            r_m2_p4   <= qmul(r_m1_cl, r_m1_p3);
        end
    end

    // x term, 2^16 scaling, fold into right half-plane
    always_comb begin
        w_tx = {r_m2_p2[RW-1], r_m2_p2} - {r_m2_p4[RW-1], r_m2_p4};
        w_xw = t_vw'(w_tx) <<< 16;
        w_yw = t_vw'(r_m2_ty) <<< 16;
        n_v0.zero = (w_tx == '0) && (r_m2_ty == '0);
        if (w_xw[VW-1]) begin
            n_v0.x = -w_xw;
            n_v0.y = -w_yw;
            n_v0.z = HALF_TURN;
        end else begin
            n_v0.x = w_xw;
            n_v0.y = w_yw;
            n_v0.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            vec_v[0] <= 1'b0;
        end else if (w_en) begin
            vec_v[0] <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            vec_d[0] <= n_v0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_vec
        pa_vec_stage #(.STEP(g)) u_vec (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (vec_v[g]),
            .i_data  (vec_d[g]),
            .o_valid (vec_v[g+1]),
            .o_data  (vec_d[g+1])
        );
    end

    // last vectoring stage is the output register; a null vector gives zero
    assign o_valid          = vec_v[STEPS];
    assign o_position_angle = vec_d[STEPS].zero ? '0 : vec_d[STEPS].z;

    `PA_ASSERT_IMP(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid, "stall without result")
    `PA_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid, "held result lost")
    `PA_ASSERT_NXT(a_m2_frozen, i_clk, i_rst_n, o_stall, $stable(r_m2_v), "pipeline moved in stall")

endmodule

>>> sim/parallactic_angle_unit_tb.sv
`timescale 1ns / 1ps
module parallactic_angle_unit_tb;
    import pa_pkg::*;

    localparam int STEPS     = 30;
    localparam int LATENCY   = 2 * STEPS + 4;
    localparam int STALL_CAP = 20000;
    localparam logic [31:0] QUARTER = 32'h4000_0000;

    // arctangent of 2^-i in turn units
    localparam int unsigned ARC_TURNS [0:39] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1,
        1, 0, 0, 0, 0,
        0, 0, 0, 0, 0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic signed [31:0] i_first_angle = '0;
    logic signed [31:0] i_second_angle = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_position_angle;

    logic [31:0] latitude_now = '0;
    logic [31:0] angles_due [$];
    int          idle_pct = 34;
    int          errors = 0;
    int          quiet_cycles = 0;

    parallactic_angle_unit #(.CORDIC_STEPS(STEPS)) i_dut (.*);

    always #4 i_clk = ~i_clk;

    // cordic sine and cosine of a binary angle, q2.30
    function automatic void cordic_sin_cos(input logic [31:0] ang,
                                           output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ARC_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ARC_TURNS[i]);
            end
        end
        case (ang[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> 30;
    endfunction

    // cordic vectoring arctangent in turn units
    function automatic logic [31:0] cordic_atan2(input longint y, input longint x);
        logic [31:0] z;
        longint dx, dy;
        z = '0;
        if (x == 0 && y == 0) return '0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            x = -x; y = -y; z = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ARC_TURNS[i];
            end else begin
                x -= dx; y += dy; z -= ARC_TURNS[i];
            end
        end
        return z;
    endfunction

    function automatic logic [31:0] parallactic(input logic [31:0] lat, input logic mode,
                                                input logic [31:0] a1, input logic [31:0] a2);
        longint cl, sl, c1, s1, c2, s2, ty, tx;
        cordic_sin_cos(lat, cl, sl);
        cordic_sin_cos(a1, c1, s1);
        cordic_sin_cos(a2, c2, s2);
        ty = q30_mul(cl, s1);
        if (!mode) ty = -ty;
        tx = q30_mul(sl, c2) - q30_mul(cl, q30_mul(s2, c1));
        return cordic_atan2(ty, tx);
    endfunction

    // one input transfer, idling at random beforehand
    task automatic send_position(input logic mode, input logic [31:0] a1,
                                 input logic [31:0] a2);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode = mode;
        i_first_angle = a1;
        i_second_angle = a2;
        do @(posedge i_clk); while (o_stall);
        angles_due.push_back(parallactic(latitude_now, mode, a1, a2));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // latitude only changes with the pipeline drained
    task automatic set_latitude(input logic [31:0] lat);
        wait (angles_due.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = lat;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        latitude_now = lat;
    endtask

    function automatic logic [31:0] rand_elevation();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return QUARTER * $urandom_range(0, 3);
            default: return 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000);
        endcase
    endfunction

    // poles, zenith, quadrant edges and both modes at reset latitude, then at the poles and beyond
    task automatic test_directed();
        send_position(1'b0, 32'h0, 32'h0);
        send_position(1'b1, 32'h0, 32'h0);
        send_position(1'b0, 32'h7fff_ffff, 32'h4000_0000);
        send_position(1'b1, 32'h8000_0000, 32'hc000_0000);
        send_position(1'b0, QUARTER, 32'h2000_0000);
        send_position(1'b1, 32'hc000_0000, 32'he000_0000);
        send_position(1'b0, 32'hffff_ffff, 32'h0000_0001);
        set_latitude(QUARTER);
        // zenith at the pole, both atan2 terms close to zero
        send_position(1'b0, 32'h0, QUARTER);
        send_position(1'b1, 32'h0, QUARTER);
        send_position(1'b0, 32'h8000_0000, 32'h0);
        send_position(1'b1, 32'h4000_0000, 32'hc000_0000);
        set_latitude(32'hc000_0000);
        send_position(1'b0, 32'h0, 32'hc000_0000);
        send_position(1'b1, 32'h8000_0000, QUARTER);
        send_position(1'b0, 32'h1234_5678, 32'h1000_0000);
        // latitude beyond the pole is wrapped, not rejected
        set_latitude(32'h8000_0000);
        send_position(1'b0, 32'h2000_0000, 32'h1000_0000);
        send_position(1'b1, 32'he000_0000, 32'h5000_0000);
        set_latitude(32'h7fff_ffff);
        send_position(1'b1, 32'h0000_0001, 32'h8000_0000);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0)
                set_latitude(n % 300 == 0 ? $urandom
                             : 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000));
            // no idling on either side for one stretch
            idle_pct = (n >= 400 && n < 550) ? 0 : 34;
            send_position(1'($urandom), $urandom, rand_elevation());
        end
        idle_pct = 34;
    endtask

    // random stall on the result side
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < idle_pct);

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (angles_due.size() == 0) begin
                $error("position_angle: unexpected transfer, actual %h", o_position_angle);
                errors++;
            end else begin
                if (o_position_angle !== angles_due[0]) begin
                    $error("position_angle: expected %h actual %h",
                           angles_due[0], o_position_angle);
                    errors++;
                end
                void'(angles_due.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(850);
        wait (angles_due.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
